// File: design/info_frame_stuffing_encoder_defines.svh
// Assertion macros for the information-frame stuffing encoder.
// Used by the top level only; the macros refer to its clk_i and rst_ni.
`ifndef INFO_FRAME_STUFFING_ENCODER_DEFINES_SVH
`define INFO_FRAME_STUFFING_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define IFSE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ifse assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define IFSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ifse assertion failed");

`endif

// File: design/ifse_pkg.sv
// Shared constants, types and helpers of the information-frame stuffing encoder.
// No dependencies; imported by every module of the block.
package ifse_pkg;

  // Line protocol bytes.
  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7D;
  localparam logic [7:0] EscXor   = 8'h20;

  // Register reset values.
  localparam logic [7:0] AddressReset = 8'h03;
  localparam logic [7:0] ControlReset = 8'h00;

  // Register indexes on the configuration port.
  localparam logic RegAddress = 1'b0;
  localparam logic RegControl = 1'b1;

  // Default depth of the request queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  // One classified request: everything the back end needs to emit its bytes.
  typedef struct packed {
    logic       hdr;   // frame opens with this byte, emit the header first
    logic [7:0] addr;  // header address snapshot
    logic [7:0] ctrl;  // header control snapshot
    logic [7:0] data;  // payload byte, unstuffed
    logic       last;  // close the frame after this byte
    logic [7:0] bcc;   // running XOR including this byte
  } cmd_t;

  // True for bytes that must be escaped on the line.
  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FlagByte) || (b == EscByte);
  endfunction

endpackage

// File: design/info_frame_stuffing_encoder.sv
// Information-frame stuffing encoder.
// Payload bytes enter on the in_ channel (valid/stall), one request per byte,
// with last_byte_i set on the final byte of a frame. Line bytes leave on the
// out_ channel, one per cycle unless stalled; frame_end_o marks the closing flag.
// A frame's first byte is preceded by the header 7E, address, control and
// their XOR; payload and check bytes are escaped (7E -> 7D 5E, 7D -> 7D 5D).
// An accepted request is written into the request queue; the back end then
// loads its line bytes one by one into the output register that drives out_.
// The back end emits one line byte per cycle unless the output stalls: a payload
// byte gives 1 or 2 line bytes, a header 4 and a close 2 or 3. The request queue
// lets intake run ahead of the output by QueueDepth requests.
// Stalling the output holds the current byte; once the queue fills,
// in_stall_o rises. Reset empties the queue and output register, closes any
// open frame, and sets address to 03 and control to 00.
// Registers at byte addresses 0 (address) and 4 (control). The user must write them
// over the APB-style port only while the block is idle; the block does not enforce it.
`include "info_frame_stuffing_encoder_defines.svh"

module info_frame_stuffing_encoder #(
  parameter int unsigned QueueDepth = ifse_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o
);
  import ifse_pkg::*;

  logic [7:0] address_q;
  logic [7:0] control_q;
  logic       cfg_we;
  logic       cfg_idx;

  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  // Register file: always ready, written on the access phase.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q <= AddressReset;
      control_q <= ControlReset;
    end else if (cfg_we) begin
      if (cfg_idx == RegAddress) begin
        address_q <= pwdata[7:0];
      end else begin
        control_q <= pwdata[7:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      RegAddress: prdata = {24'h0, address_q};
      RegControl: prdata = {24'h0, control_q};
      default:    prdata = 32'h0;
    endcase
  end

  ifse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .address_byte_i (address_q),
    .control_byte_i (control_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  ifse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ifse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_cmd),
    .head_valid_i (!q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .frame_end_o  (frame_end_o)
  );

  // A closing marker always carries the flag byte.
  `IFSE_ASSERT_IMPL(a_end_is_flag, out_valid_o && frame_end_o, out_byte_o == FlagByte)
  // The queue is never both full and empty.
  `IFSE_ASSERT_IMPL(a_queue_sane, q_full, !q_empty)
  // An accepted request is waiting in the queue on the next cycle.
  `IFSE_ASSERT_NEXT(a_push_lands, in_valid_i && !in_stall_o, !q_empty)
  // The back end pops only a request that is present.
  `IFSE_ASSERT_IMPL(a_pop_nonempty, pop, !q_empty)

endmodule

// File: design/ifse_front.sv
// Front end: accepts payload bytes, tracks frame state and the running XOR,
// and turns each byte into a request for the queue. Depends on ifse_pkg.
module ifse_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  input  logic [7:0]      address_byte_i,
  input  logic [7:0]      control_byte_i,
  input  logic            q_full_i,
  output logic            push_o,
  output ifse_pkg::cmd_t  cmd_o
);
  import ifse_pkg::*;

  logic       frame_open_q, frame_open_d;
  logic [7:0] parity_q, parity_d;

  // Accept whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Build the request; the header snapshot is taken at acceptance.
  always_comb begin
    cmd_o.hdr  = !frame_open_q;
    cmd_o.addr = address_byte_i;
    cmd_o.ctrl = control_byte_i;
    cmd_o.data = data_byte_i;
    cmd_o.last = last_byte_i;
    cmd_o.bcc  = parity_q ^ data_byte_i;
  end

  // Frame state advances once per accepted request; a closing byte clears it.
  always_comb begin
    frame_open_d = frame_open_q;
    parity_d     = parity_q;
    if (push_o) begin
      frame_open_d = !last_byte_i;
      parity_d     = last_byte_i ? 8'h00 : (parity_q ^ data_byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      parity_q     <= 8'h00;
    end else begin
      frame_open_q <= frame_open_d;
      parity_q     <= parity_d;
    end
  end

endmodule

// File: design/ifse_queue.sv
// Small request queue between the front and back ends.
// Depends on ifse_pkg for the request type.
module ifse_queue #(
  parameter int unsigned Depth = ifse_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ifse_pkg::cmd_t  cmd_i,
  input  logic            pop_i,
  output ifse_pkg::cmd_t  head_o,
  output logic            full_o,
  output logic            empty_o
);
  import ifse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; entries are read only after being written.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: design/ifse_back.sv
// Back end: walks the request at the head of the queue byte by byte and
// feeds the output register. Depends on ifse_pkg.
module ifse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ifse_pkg::cmd_t  head_i,
  input  logic            head_valid_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            frame_end_o
);
  import ifse_pkg::*;

  // Position within one request.
  localparam logic [3:0] PhFlag  = 4'd0;
  localparam logic [3:0] PhAddr  = 4'd1;
  localparam logic [3:0] PhCtrl  = 4'd2;
  localparam logic [3:0] PhHxor  = 4'd3;
  localparam logic [3:0] PhData  = 4'd4;
  localparam logic [3:0] PhData2 = 4'd5;
  localparam logic [3:0] PhBcc   = 4'd6;
  localparam logic [3:0] PhBcc2  = 4'd7;
  localparam logic [3:0] PhClose = 4'd8;

  logic       started_q, started_d;
  logic [3:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       frame_end_q;

  logic [3:0] cur_phase;
  logic [3:0] nxt_phase;
  logic [7:0] byte_c;
  logic       end_c;
  logic       done_c;
  logic       load;

  // A fresh head starts at its header or directly at its payload byte.
  assign cur_phase = started_q ? phase_q : (head_i.hdr ? PhFlag : PhData);

  // Byte selection and sequencing for the current position.
  always_comb begin
    byte_c    = FlagByte;
    end_c     = 1'b0;
    done_c    = 1'b0;
    nxt_phase = PhFlag;
    case (cur_phase)
      PhFlag: begin
        byte_c    = FlagByte;
        nxt_phase = PhAddr;
      end
      PhAddr: begin
        byte_c    = head_i.addr;
        nxt_phase = PhCtrl;
      end
      PhCtrl: begin
        byte_c    = head_i.ctrl;
        nxt_phase = PhHxor;
      end
      PhHxor: begin
        byte_c    = head_i.addr ^ head_i.ctrl;
        nxt_phase = PhData;
      end
      PhData: begin
        if (needs_esc(head_i.data)) begin
          byte_c    = EscByte;
          nxt_phase = PhData2;
        end else begin
          byte_c    = head_i.data;
          done_c    = !head_i.last;
          nxt_phase = PhBcc;
        end
      end
      PhData2: begin
        byte_c    = head_i.data ^ EscXor;
        done_c    = !head_i.last;
        nxt_phase = PhBcc;
      end
      PhBcc: begin
        if (needs_esc(head_i.bcc)) begin
          byte_c    = EscByte;
          nxt_phase = PhBcc2;
        end else begin
          byte_c    = head_i.bcc;
          nxt_phase = PhClose;
        end
      end
      PhBcc2: begin
        byte_c    = head_i.bcc ^ EscXor;
        nxt_phase = PhClose;
      end
      PhClose: begin
        byte_c = FlagByte;
        end_c  = 1'b1;
        done_c = 1'b1;
      end
      default: begin
        byte_c = FlagByte;
        done_c = 1'b1;
      end
    endcase
  end

  // Load the output register when it is empty or being drained.
  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && done_c;

  always_comb begin
    started_d   = started_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      started_d   = !done_c;
      phase_d     = nxt_phase;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      phase_q     <= PhFlag;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload holds while stalled.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q  <= byte_c;
      frame_end_q <= end_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;

endmodule

// File: test/tb_top.sv
// Testbench for info_frame_stuffing_encoder: directed and random payload requests,
// with every line byte checked against a frame encoder predictor kept in this file.
// Depends on ifse_pkg and the RTL of the block; reads no files.
module tb_top;
  import ifse_pkg::*;

  localparam int CycleLimit = 300000;

  // One byte of the line stream as it should leave the block.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
  } line_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;

  // Predictor state: register copies, frame status and the XOR check byte.
  logic [7:0] addr_reg = AddressReset;
  logic [7:0] ctrl_reg = ControlReset;
  logic       frame_is_open = 1'b0;
  logic [7:0] payload_xor = '0;
  line_t      line_q[$];
  line_t      want;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  info_frame_stuffing_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

  always #5 clk_i = ~clk_i;

  // Appends one line byte to the expected stream.
  function automatic void push_line(input logic [7:0] b, input logic fend);
    line_t l;
    l.line_byte = b;
    l.frame_end = fend;
    line_q.push_back(l);
  endfunction

  // Flag and escape bytes go out as an escape followed by the byte with bit 5 flipped.
  function automatic void push_escaped(input logic [7:0] b);
    if (b == FlagByte || b == EscByte) begin
      push_line(EscByte, 1'b0);
      push_line(b ^ EscXor, 1'b0);
    end else begin
      push_line(b, 1'b0);
    end
  endfunction

  // Expected line bytes for one accepted payload request.
  function automatic void frame_encode(input logic [7:0] d, input logic last);
    if (!frame_is_open) begin
      push_line(FlagByte, 1'b0);
      push_line(addr_reg, 1'b0);
      push_line(ctrl_reg, 1'b0);
      push_line(addr_reg ^ ctrl_reg, 1'b0);
      frame_is_open = 1'b1;
      payload_xor = '0;
    end
    push_escaped(d);
    payload_xor ^= d;
    if (last) begin
      push_escaped(payload_xor);
      push_line(FlagByte, 1'b1);
      frame_is_open = 1'b0;
      payload_xor = '0;
    end
  endfunction

  // Sends one payload request, with random idle cycles ahead of it.
  task automatic send_payload(input logic [7:0] d, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    frame_encode(d, last);
  endtask

  // Waits until every expected line byte has come out, then a few more cycles.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (line_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Register write over the configuration port: setup cycle, then access cycle.
  task automatic reg_write(input logic idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegAddress) begin
      addr_reg = val;
    end else begin
      ctrl_reg = val;
    end
  endtask

  // Single-byte frames: extremes of the byte and check bytes that need escaping.
  task automatic test_single_byte_frames;
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b1);
    send_payload(FlagByte, 1'b1);
    send_payload(EscByte, 1'b1);
    drain();
  endtask

  // Escaped payload bytes inside longer frames, with escaped check bytes.
  task automatic test_escaped_payload;
    send_payload(FlagByte, 1'b0);
    send_payload(EscByte, 1'b0);
    send_payload(8'h55, 1'b0);
    send_payload(8'h2B, 1'b1);
    send_payload(8'h01, 1'b0);
    send_payload(8'h7F, 1'b1);
    drain();
  endtask

  // Header fields at their extremes, and a register change while a frame is open.
  task automatic test_header_registers;
    reg_write(RegAddress, 8'hFF);
    reg_write(RegControl, 8'hFF);
    send_payload(8'hA5, 1'b1);
    drain();
    reg_write(RegAddress, 8'h00);
    reg_write(RegControl, 8'h00);
    send_payload(8'h5A, 1'b1);
    drain();
    reg_write(RegAddress, FlagByte);
    reg_write(RegControl, EscByte);
    send_payload(8'h11, 1'b0);
    drain();
    // The open frame keeps going without a new header; the next frame picks up the change.
    reg_write(RegAddress, 8'h3C);
    send_payload(8'h22, 1'b1);
    send_payload(8'h33, 1'b1);
    drain();
  endtask

  // Random frames of mostly short length, biased toward bytes that need escaping; then new random header registers.
  task automatic test_random_frames(input int n, input int unsigned idle,
                                    input int unsigned stall);
    logic [7:0] d;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      d = ($urandom_range(3) == 0) ? ($urandom_range(1) ? FlagByte : EscByte)
                                   : 8'($urandom);
      send_payload(d, $urandom_range(5) == 0);
    end
    drain();
    reg_write(RegAddress, 8'($urandom));
    reg_write(RegControl, 8'($urandom));
  endtask

  // Receiver stalls at random.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Compares each accepted line byte with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (line_q.size() == 0) begin
        $display("%0t: unexpected line byte %02h frame_end %0b", $time, out_byte_o,
                 frame_end_o);
        errors++;
      end else begin
        want = line_q.pop_front();
        if (out_byte_o !== want.line_byte) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.line_byte,
                   out_byte_o);
          errors++;
        end
        if (frame_end_o !== want.frame_end) begin
          $display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end,
                   frame_end_o);
          errors++;
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[info_frame_stuffing_encoder] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_byte_frames();
    test_escaped_payload();
    test_header_registers();
    test_random_frames(45, 0, 0);
    test_random_frames(45, 74, 0);
    test_random_frames(45, 0, 74);
    test_random_frames(45, 30, 30);
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && line_q.size() == 0) begin
      $display("[info_frame_stuffing_encoder] OK");
    end else begin
      $display("[info_frame_stuffing_encoder] ERROR");
    end
    $finish;
  end

endmodule

// File: info_frame_stuffing_encoder.f
+incdir+design
design/ifse_pkg.sv
design/ifse_front.sv
design/ifse_queue.sv
design/ifse_back.sv
design/info_frame_stuffing_encoder.sv
test/tb_top.sv
